[hdl/efsa_pkg.sv]
package efsa_pkg;

	localparam int MAX_SERVERS   = 4;
	localparam int NUM_TIME_REGS = 4;
	localparam int TIME_W        = 16;
	localparam int ACT_W         = 3;
	localparam int IDX_W         = 2;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int SRV_W         = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W         = $clog2(MAX_SERVERS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SERVERS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TIME_0 = CFG_IDX_W'(1);

	localparam logic [ACT_W-1:0]  ACTIVE_RESET  = ACT_W'(4);
	localparam logic [TIME_W-1:0] SERVICE_RESET = TIME_W'(1);

	typedef struct packed {
		logic start;
		logic step;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} sts_t;

endpackage

[hdl/efsa_if.sv]
interface efsa_job_if;
	logic valid;
	logic ready;
	logic start_new;
	modport source (output valid, output start_new, input ready);
	modport sink (input valid, input start_new, output ready);
endinterface

interface efsa_res_if;
	logic                       valid;
	logic                       ready;
	logic [efsa_pkg::IDX_W-1:0] server_index;
	modport source (output valid, output server_index, input ready);
	modport sink (input valid, input server_index, output ready);
endinterface

interface efsa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [efsa_pkg::CFG_IDX_W-1:0]  index;
	logic [efsa_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/efsa_ctrl.sv]
module efsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  logic           res_ready,
	output logic           res_valid,
	output efsa_pkg::cmd_t cmd,
	input  efsa_pkg::sts_t sts
);
	import efsa_pkg::*;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free  = !res_valid_q || res_ready;
	assign job_ready  = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.start  = (state_q == ST_IDLE) && job_valid;
		cmd.step   = (state_q == ST_SCAN) && !sts.scan_done;
		cmd.update = (state_q == ST_SCAN) && sts.scan_done && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmd.update) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.update) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_update_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> sts.scan_done)
		else $error("update issued before the scan finished");

	a_update_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> res_valid)
		else $error("update did not present a result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready && !cmd.update |=> res_valid)
		else $error("pending result dropped");

endmodule

[hdl/efsa_dp.sv]
module efsa_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  efsa_pkg::cmd_t                      cmd,
	output efsa_pkg::sts_t                      sts,
	input  logic                                start_new,
	input  logic                                cfg_we,
	input  logic [efsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [efsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [efsa_pkg::IDX_W-1:0]          server_index
);
	import efsa_pkg::*;

	logic [ACT_W-1:0]  active_q;
	logic [TIME_W-1:0] svc_q [MAX_SERVERS];
	logic [TIME_W-1:0] rem_q [MAX_SERVERS];
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  n_act;
	logic [SRV_W-1:0]  best_q;
	logic [TIME_W-1:0] min_q;
	logic [TIME_W-1:0] rem_j;
	logic [IDX_W-1:0]  index_q;

	// clamp the active count to one .. MAX_SERVERS
	always_comb begin
		if (active_q == '0) begin
			n_act = CNT_W'(1);
		end else if (32'(active_q) > MAX_SERVERS) begin
			n_act = CNT_W'(MAX_SERVERS);
		end else begin
			n_act = CNT_W'(active_q);
		end
	end

	assign rem_j         = rem_q[j_q[SRV_W-1:0]];
	assign sts.scan_done = (j_q >= n_act);
	assign server_index  = index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			for (int i = 0; i < MAX_SERVERS; i++) begin
				svc_q[i] <= SERVICE_RESET;
				rem_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE_SERVERS) begin
					active_q <= cfg_data[ACT_W-1:0];
				end
				for (int i = 0; i < MAX_SERVERS; i++) begin
					if (i < NUM_TIME_REGS &&
					    32'(cfg_index) == 32'(REG_SERVICE_TIME_0) + i) begin
						svc_q[i] <= cfg_data[TIME_W-1:0];
					end
				end
			end
			if (cmd.start && start_new) begin
				for (int i = 0; i < MAX_SERVERS; i++) begin
					rem_q[i] <= '0;
				end
			end else if (cmd.update) begin
				// advance time on every active server, reload the winner
				for (int i = 0; i < MAX_SERVERS; i++) begin
					if (32'(i) < 32'(n_act)) begin
						if (SRV_W'(i) == best_q) begin
							rem_q[i] <= svc_q[i];
						end else begin
							rem_q[i] <= rem_q[i] - min_q;
						end
					end
				end
			end
		end
	end

	// scan registers: one server compared per step
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_q <= '0;
			j_q    <= CNT_W'(1);
			min_q  <= start_new ? '0 : rem_q[0];
		end else if (cmd.step) begin
			j_q <= j_q + CNT_W'(1);
			if (rem_j < min_q) begin
				best_q <= j_q[SRV_W-1:0];
				min_q  <= rem_j;
			end
		end
		if (cmd.update) begin
			index_q <= IDX_W'(best_q);
		end
	end

endmodule

[hdl/earliest_free_server_assign_core.sv]
// Channel  Role  Handshake      Payload
// job      sink  valid / ready  start_new (1 bit)
// res      src   valid / ready  server_index (2 bits)
// cfg      sink  valid / ready  index (3 bits), data (16 bits); ready tied high
//
// A job's scan steps through the active servers (count clamped to 1 .. 4) one
// at a time through the single comparator, then an update advances the active
// servers and reloads the winner; no new job is taken until that update.
// A finished result waits in the output register; a new job is taken while it
// waits, and the update stalls only if the previous result is still unread.
// Reset clears all remaining times, sets four active servers and unit times.
module earliest_free_server_assign_core (
	input  logic clk,
	input  logic arst_n,
	efsa_job_if.sink   job,
	efsa_res_if.source res,
	efsa_cfg_if.sink   cfg
);
	import efsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// configuration is always taken in one beat
	assign cfg.ready = 1'b1;

	efsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job.valid),
		.job_ready (job.ready),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: server state, min scan and the result register
	efsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.start_new    (job.start_new),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.server_index (res.server_index)
	);

endmodule
